/* hw/rtl/sps_pkg.sv */
// types, constants and the coil table shared by the stepper sequencer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sps_pkg;

  localparam int unsigned GAP_BITS  = 16;
  localparam int unsigned STEP_BITS = 32;
  localparam int unsigned LEFT_BITS = STEP_BITS - 1;
  localparam int unsigned RAMP_BITS = 8;
  localparam int unsigned ADDR_BITS = 5;
  localparam int unsigned DATA_BITS = 32;

  localparam logic [2:0] NUM_MODES = 3'd6;

  localparam logic [2:0] MODE_WAVE_ABCD = 3'd0;
  localparam logic [2:0] MODE_WAVE_ACBD = 3'd1;
  localparam logic [2:0] MODE_WAVE_ABDC = 3'd2;
  localparam logic [2:0] MODE_DUAL_ABCD = 3'd3;
  localparam logic [2:0] MODE_DUAL_ACBD = 3'd4;
  localparam logic [2:0] MODE_DUAL_ABDC = 3'd5;

  localparam logic [2:0]           RST_MODE       = MODE_DUAL_ABCD;
  localparam logic [GAP_BITS-1:0]  RST_PRECHARGE  = 16'd50;
  localparam logic [GAP_BITS-1:0]  RST_FINAL_HOLD = 16'd100;
  localparam logic [GAP_BITS-1:0]  RST_START_IV   = 16'd10;
  localparam logic [GAP_BITS-1:0]  RST_MIN_IV     = 16'd2;
  localparam logic [RAMP_BITS-1:0] RST_RAMP_EVERY = 8'd4;

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_MOVE    = 2'd1,
    KIND_STOP    = 2'd2,
    KIND_PATTERN = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAGE_IDLE      = 2'd0,
    STAGE_PRECHARGE = 2'd1,
    STAGE_RUN       = 2'd2,
    STAGE_HOLD      = 2'd3
  } stage_e;

  typedef enum logic [2:0] {
    REG_SEQUENCE_MODE  = 3'd0,
    REG_REVERSE_WIRING = 3'd1,
    REG_PRECHARGE      = 3'd2,
    REG_FINAL_HOLD     = 3'd3,
    REG_START_INTERVAL = 3'd4,
    REG_MIN_INTERVAL   = 3'd5,
    REG_RAMP_EVERY     = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [2:0]           mode;
    logic                 reverse;
    logic [GAP_BITS-1:0]  precharge;
    logic [GAP_BITS-1:0]  final_hold;
    logic [GAP_BITS-1:0]  start_iv;
    logic [GAP_BITS-1:0]  min_iv;
    logic [RAMP_BITS-1:0] ramp_every;
    logic                 mode_load;
  } cfg_t;

  typedef struct packed {
    kind_e                       kind;
    logic signed [STEP_BITS-1:0] steps;
    logic [GAP_BITS-1:0]         interval;
    logic [3:0]                  pattern;
  } item_t;

  typedef struct packed {
    logic [3:0]           coils;
    logic                 busy;
    stage_e               stage;
    logic                 accepted;
    logic [LEFT_BITS-1:0] steps_left;
  } res_t;

  function automatic logic [3:0] coil_lookup(input logic [2:0] mode, input logic [1:0] phase);
    logic [15:0] row;
    case (mode)
      MODE_WAVE_ABCD: row = 16'h8421;
      MODE_WAVE_ACBD: row = 16'h8241;
      MODE_WAVE_ABDC: row = 16'h4821;
      MODE_DUAL_ABCD: row = 16'h9C63;
      MODE_DUAL_ACBD: row = 16'h9A65;
      MODE_DUAL_ABDC: row = 16'h5CA3;
      default:        row = 16'h8421;
    endcase
    return row[{phase, 2'b00} +: 4];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/sps_regs.sv */
// apb configuration registers of the stepper sequencer
// depends on sps_pkg
`timescale 1ns / 1ps
`default_nettype none

module sps_regs
  import sps_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [DATA_BITS-1:0] pwdata,
  output      logic [DATA_BITS-1:0] prdata,
  output      logic                 pready,
  input  wire logic                 idle_i,
  output      cfg_t                 cfg_o
);

  logic                 wr;
  reg_idx_e             idx;
  logic [2:0]           mode_q, mode_d;
  logic                 rev_q, rev_d;
  logic [GAP_BITS-1:0]  pre_q, pre_d;
  logic [GAP_BITS-1:0]  hold_q, hold_d;
  logic [GAP_BITS-1:0]  start_q, start_d;
  logic [GAP_BITS-1:0]  min_q, min_d;
  logic [RAMP_BITS-1:0] ramp_q, ramp_d;
  logic                 mode_load;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;
  assign idx    = reg_idx_e'(paddr[ADDR_BITS-1:2]);

  always_comb begin
    mode_d    = mode_q;
    rev_d     = rev_q;
    pre_d     = pre_q;
    hold_d    = hold_q;
    start_d   = start_q;
    min_d     = min_q;
    ramp_d    = ramp_q;
    mode_load = 1'b0;
    if (wr) begin
      case (idx)
        REG_SEQUENCE_MODE: begin
          if (idle_i && (pwdata[2:0] < NUM_MODES)) begin
            mode_d    = pwdata[2:0];
            mode_load = 1'b1;
          end
        end
        REG_REVERSE_WIRING: rev_d   = pwdata[0];
        REG_PRECHARGE:      pre_d   = pwdata[GAP_BITS-1:0];
        REG_FINAL_HOLD:     hold_d  = pwdata[GAP_BITS-1:0];
        REG_START_INTERVAL: start_d = pwdata[GAP_BITS-1:0];
        REG_MIN_INTERVAL:   min_d   = pwdata[GAP_BITS-1:0];
        REG_RAMP_EVERY:     ramp_d  = pwdata[RAMP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= RST_MODE;
      rev_q   <= 1'b0;
      pre_q   <= RST_PRECHARGE;
      hold_q  <= RST_FINAL_HOLD;
      start_q <= RST_START_IV;
      min_q   <= RST_MIN_IV;
      ramp_q  <= RST_RAMP_EVERY;
    end else begin
      mode_q  <= mode_d;
      rev_q   <= rev_d;
      pre_q   <= pre_d;
      hold_q  <= hold_d;
      start_q <= start_d;
      min_q   <= min_d;
      ramp_q  <= ramp_d;
    end
  end

  always_comb begin
    case (idx)
      REG_SEQUENCE_MODE:  prdata = {{(DATA_BITS-3){1'b0}}, mode_q};
      REG_REVERSE_WIRING: prdata = {{(DATA_BITS-1){1'b0}}, rev_q};
      REG_PRECHARGE:      prdata = {{(DATA_BITS-GAP_BITS){1'b0}}, pre_q};
      REG_FINAL_HOLD:     prdata = {{(DATA_BITS-GAP_BITS){1'b0}}, hold_q};
      REG_START_INTERVAL: prdata = {{(DATA_BITS-GAP_BITS){1'b0}}, start_q};
      REG_MIN_INTERVAL:   prdata = {{(DATA_BITS-GAP_BITS){1'b0}}, min_q};
      REG_RAMP_EVERY:     prdata = {{(DATA_BITS-RAMP_BITS){1'b0}}, ramp_q};
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = '{
    mode:       mode_q,
    reverse:    rev_q,
    precharge:  pre_q,
    final_hold: hold_q,
    start_iv:   start_q,
    min_iv:     min_q,
    ramp_every: ramp_q,
    mode_load:  mode_load
  };

endmodule

`default_nettype wire

/* hw/rtl/sps_core.sv */
// sequencer state and the per-word update: ticks, moves, stop, raw pattern
// depends on sps_pkg
`timescale 1ns / 1ps
`default_nettype none

module sps_core
  import sps_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  advance_i,
  input  wire item_t item_i,
  output      logic  idle_o,
  output      res_t  res_o
);

  stage_e               stage_q, stage_d;
  logic [1:0]           phase_q, phase_d;
  logic                 down_q, down_d;
  logic [LEFT_BITS-1:0] left_q, left_d;
  logic [GAP_BITS-1:0]  target_q, target_d;
  logic [GAP_BITS-1:0]  cur_q, cur_d;
  logic [GAP_BITS-1:0]  ticks_q, ticks_d;
  logic [RAMP_BITS-1:0] rc_q, rc_d;
  logic [3:0]           coils_q, coils_d;
  logic                 acc;

  logic [GAP_BITS-1:0]  tick_dec;
  logic [1:0]           phase_step;
  logic [LEFT_BITS-1:0] left_dec;
  logic [RAMP_BITS-1:0] rc_inc;
  logic                 neg;
  logic [STEP_BITS-1:0] raw;
  logic [STEP_BITS-1:0] mag;
  logic                 refuse;
  logic [GAP_BITS-1:0]  tgt;

  assign idle_o     = (stage_q == STAGE_IDLE);
  assign tick_dec   = (ticks_q == '0) ? '0 : ticks_q - GAP_BITS'(1);
  assign phase_step = phase_q + (down_q ? 2'd3 : 2'd1);
  assign left_dec   = (left_q == '0) ? '0 : left_q - LEFT_BITS'(1);
  assign rc_inc     = rc_q + RAMP_BITS'(1);
  assign raw        = item_i.steps;
  assign neg        = raw[STEP_BITS-1];
  assign mag        = neg ? (~raw + STEP_BITS'(1)) : raw;
  assign refuse     = !idle_o || (raw == '0) ||
                      (raw == {1'b1, {(STEP_BITS-1){1'b0}}});
  assign tgt        = (item_i.interval < cfg_i.min_iv) ? cfg_i.min_iv : item_i.interval;

  always_comb begin
    stage_d  = stage_q;
    phase_d  = phase_q;
    down_d   = down_q;
    left_d   = left_q;
    target_d = target_q;
    cur_d    = cur_q;
    ticks_d  = ticks_q;
    rc_d     = rc_q;
    coils_d  = coils_q;
    acc      = 1'b0;
    if (cfg_i.mode_load) begin
      phase_d = '0;
      left_d  = '0;
      stage_d = STAGE_IDLE;
      coils_d = '0;
    end else if (advance_i) begin
      case (item_i.kind)
        KIND_TICK: begin
          if (!idle_o) begin
            ticks_d = tick_dec;
            if (tick_dec == '0) begin
              if (stage_q == STAGE_HOLD) begin
                left_d  = '0;
                stage_d = STAGE_IDLE;
                coils_d = '0;
              end else begin
                stage_d = STAGE_RUN;
                phase_d = phase_step;
                coils_d = coil_lookup(cfg_i.mode, phase_step);
                left_d  = left_dec;
                if (left_dec == '0) begin
                  stage_d = STAGE_HOLD;
                  ticks_d = cfg_i.final_hold;
                end else if (cur_q > target_q) begin
                  if (rc_inc >= cfg_i.ramp_every) begin
                    cur_d   = cur_q - GAP_BITS'(1);
                    rc_d    = '0;
                    ticks_d = cur_q - GAP_BITS'(1);
                  end else begin
                    rc_d    = rc_inc;
                    ticks_d = cur_q;
                  end
                end else begin
                  ticks_d = cur_q;
                end
              end
            end
          end
        end
        KIND_MOVE: begin
          if (!refuse) begin
            acc      = 1'b1;
            down_d   = neg ^ cfg_i.reverse;
            left_d   = mag[LEFT_BITS-1:0];
            target_d = tgt;
            cur_d    = (tgt < cfg_i.start_iv) ? cfg_i.start_iv : tgt;
            rc_d     = '0;
            stage_d  = STAGE_PRECHARGE;
            coils_d  = coil_lookup(cfg_i.mode, phase_q);
            ticks_d  = cfg_i.precharge;
          end
        end
        KIND_STOP: begin
          left_d  = '0;
          stage_d = STAGE_IDLE;
          coils_d = '0;
        end
        KIND_PATTERN: begin
          left_d  = '0;
          stage_d = STAGE_IDLE;
          coils_d = item_i.pattern;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q  <= STAGE_IDLE;
      phase_q  <= '0;
      down_q   <= 1'b0;
      left_q   <= '0;
      target_q <= RST_MIN_IV;
      cur_q    <= RST_START_IV;
      ticks_q  <= '0;
      rc_q     <= '0;
      coils_q  <= '0;
    end else begin
      stage_q  <= stage_d;
      phase_q  <= phase_d;
      down_q   <= down_d;
      left_q   <= left_d;
      target_q <= target_d;
      cur_q    <= cur_d;
      ticks_q  <= ticks_d;
      rc_q     <= rc_d;
      coils_q  <= coils_d;
    end
  end

  assign res_o = '{
    coils:      coils_d,
    busy:       (stage_d != STAGE_IDLE),
    stage:      stage_d,
    accepted:   acc,
    steps_left: left_d
  };

endmodule

`default_nettype wire

/* hw/rtl/stepper_phase_sequencer_with_ramp.sv */
// four-phase stepper sequencer with linear speed ramp, top level
// an accepted input word waits in item_q; out_valid_o rises with its result in res_q once the output is free
// throughput: one word per cycle while out_ready_i keeps the output free, set by the state update in sps_core
// reset: asynchronous active low; sps_core coils released and idle, registers at defaults
// depends on sps_pkg, sps_regs, sps_core
`timescale 1ns / 1ps
`default_nettype none

module stepper_phase_sequencer_with_ramp
  import sps_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_ready_o,
  input  wire logic [1:0]                  kind_i,
  input  wire logic signed [STEP_BITS-1:0] steps_i,
  input  wire logic [GAP_BITS-1:0]         interval_i,
  input  wire logic [3:0]                  pattern_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  output      logic [3:0]                  coils_o,
  output      logic                        busy_res_o,
  output      logic [1:0]                  stage_o,
  output      logic                        accepted_o,
  output      logic [LEFT_BITS-1:0]        steps_left_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ADDR_BITS-1:0]        paddr,
  input  wire logic [DATA_BITS-1:0]        pwdata,
  output      logic [DATA_BITS-1:0]        prdata,
  output      logic                        pready
);

  cfg_t  cfg;
  logic  idle;
  logic  in_vld_q, in_vld_d;
  item_t item_q;
  logic  out_vld_q, out_vld_d;
  res_t  res_q;
  res_t  res;
  logic  advance;
  logic  take;

  sps_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .idle_i  (idle),
    .cfg_o   (cfg)
  );

  sps_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .advance_i (advance),
    .item_i    (item_q),
    .idle_o    (idle),
    .res_o     (res)
  );

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign take       = in_valid_i && in_ready_o;
  assign in_vld_d   = take ? 1'b1 : (advance ? 1'b0 : in_vld_q);
  assign out_vld_d  = advance ? 1'b1 : (out_ready_i ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= '{kind: kind_e'(kind_i), steps: steps_i, interval: interval_i,
                  pattern: pattern_i};
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign coils_o      = res_q.coils;
  assign busy_res_o   = res_q.busy;
  assign stage_o      = res_q.stage;
  assign accepted_o   = res_q.accepted;
  assign steps_left_o = res_q.steps_left;

endmodule

`default_nettype wire

/* test/tb.sv */
// testbench for the four-phase stepper sequencer with speed ramp
// checks every result word against a cycle-free model of the coil/ramp state
// depends on sps_pkg and stepper_phase_sequencer_with_ramp
`timescale 1ns / 1ps

module tb;
  import sps_pkg::*;

  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned MOVE_TICK_CAP  = 60;
  localparam logic [2:0]  MODE_UNUSED    = 3'd7;
  localparam logic [2:0]  BAD_REG_IDX    = 3'd7;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic [1:0]                  item_kind = KIND_TICK;
  logic signed [STEP_BITS-1:0] item_steps = '0;
  logic [GAP_BITS-1:0]         item_interval = '0;
  logic [3:0]                  item_pattern = '0;
  logic                        out_ready = 1'b0;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [ADDR_BITS-1:0]        paddr = '0;
  logic [DATA_BITS-1:0]        pwdata = '0;

  wire                         in_ready_o;
  wire                         out_valid_o;
  wire [3:0]                   coils_o;
  wire                         busy_res_o;
  wire [1:0]                   stage_o;
  wire                         accepted_o;
  wire [LEFT_BITS-1:0]         steps_left_o;
  wire [DATA_BITS-1:0]         prdata;
  wire                         pready;

  // motor model: settings and state
  logic [2:0]           cfg_mode;
  logic                 cfg_reverse;
  logic [GAP_BITS-1:0]  cfg_precharge, cfg_hold, cfg_start_iv, cfg_min_iv;
  logic [RAMP_BITS-1:0] cfg_ramp_every;
  logic [1:0]           m_phase;
  logic                 m_down;
  logic [31:0]          m_left;
  logic [GAP_BITS-1:0]  m_target, m_gap, m_ticks;
  logic [RAMP_BITS-1:0] m_ramp;
  stage_e               m_stage;
  logic [3:0]           m_coils;

  res_t        expected_drive_q[$];
  int unsigned mismatch_count = 0;
  int unsigned words_checked = 0;
  int unsigned useful_words = 0;
  int unsigned moves_taken = 0;
  int unsigned reg_writes = 0;
  int unsigned settings_phases = 0;
  int unsigned quiet_cycles = 0;
  bit          steady_send = 1'b0;
  bit          steady_take = 1'b0;
  bit          holdoff_req = 1'b0;

  stepper_phase_sequencer_with_ramp u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .kind_i       (item_kind),
    .steps_i      (item_steps),
    .interval_i   (item_interval),
    .pattern_i    (item_pattern),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .coils_o      (coils_o),
    .busy_res_o   (busy_res_o),
    .stage_o      (stage_o),
    .accepted_o   (accepted_o),
    .steps_left_o (steps_left_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  function automatic logic [3:0] phase_coils(input logic [2:0] mode, input logic [1:0] ph);
    logic [3:0][3:0] row;
    case (mode)
      MODE_WAVE_ABCD: row = {4'h8, 4'h4, 4'h2, 4'h1};
      MODE_WAVE_ACBD: row = {4'h8, 4'h2, 4'h4, 4'h1};
      MODE_WAVE_ABDC: row = {4'h4, 4'h8, 4'h2, 4'h1};
      MODE_DUAL_ABCD: row = {4'h9, 4'hC, 4'h6, 4'h3};
      MODE_DUAL_ACBD: row = {4'h9, 4'hA, 4'h6, 4'h5};
      default:        row = {4'h5, 4'hC, 4'hA, 4'h3};
    endcase
    return row[ph];
  endfunction

  function automatic void release_motor(input logic [3:0] bits);
    m_left  = '0;
    m_stage = STAGE_IDLE;
    m_coils = bits;
  endfunction

  function automatic res_t predict_drive_word(input kind_e k, input logic signed [31:0] s,
                                              input logic [15:0] iv, input logic [3:0] pat);
    res_t r;
    logic took;
    took = 1'b0;
    case (k)
      KIND_TICK: if (m_stage != STAGE_IDLE) begin
        if (m_ticks != 0) m_ticks = m_ticks - 1'b1;
        if (m_ticks == 0) begin
          if (m_stage == STAGE_HOLD) begin
            release_motor(4'h0);
          end else begin
            m_stage = STAGE_RUN;
            m_phase = m_phase + (m_down ? 2'd3 : 2'd1);
            m_coils = phase_coils(cfg_mode, m_phase);
            if (m_left != 0) m_left = m_left - 1;
            if (m_left == 0) begin
              m_stage = STAGE_HOLD;
              m_ticks = cfg_hold;
            end else begin
              // ramp: one tick shorter every cfg_ramp_every steps
              if (m_gap > m_target) begin
                m_ramp = m_ramp + 1'b1;
                if (m_ramp >= cfg_ramp_every) begin
                  m_gap  = m_gap - 1'b1;
                  m_ramp = '0;
                end
              end
              m_ticks = m_gap;
            end
          end
        end
      end
      KIND_MOVE: if (m_stage == STAGE_IDLE && s != 0 && s != 32'sh8000_0000) begin
        took     = 1'b1;
        m_down   = s[31] ^ cfg_reverse;
        m_left   = s[31] ? (~s + 1) : s;
        m_target = (iv < cfg_min_iv) ? cfg_min_iv : iv;
        m_gap    = (m_target < cfg_start_iv) ? cfg_start_iv : m_target;
        m_ramp   = '0;
        m_stage  = STAGE_PRECHARGE;
        m_coils  = phase_coils(cfg_mode, m_phase);
        m_ticks  = cfg_precharge;
      end
      KIND_STOP: release_motor(4'h0);
      default:   release_motor(pat);
    endcase
    r.coils      = m_coils;
    r.busy       = (m_stage != STAGE_IDLE);
    r.stage      = m_stage;
    r.accepted   = took;
    r.steps_left = m_left[LEFT_BITS-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("mismatch on %s: got 0x%0h, expected 0x%0h (word %0d)",
               what, got, want, words_checked);
  endtask

  task automatic send_word(input kind_e k, input logic signed [31:0] s,
                           input logic [15:0] iv, input logic [3:0] pat);
    int unsigned gap;
    gap = steady_send ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    item_kind     <= k;
    item_steps    <= s;
    item_interval <= iv;
    item_pattern  <= pat;
    do @(posedge clk); while (!in_ready_o);
    if (k != KIND_TICK || m_stage != STAGE_IDLE) useful_words++;
    expected_drive_q.push_back(predict_drive_word(k, s, iv, pat));
    if (expected_drive_q[$].accepted) moves_taken++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_drive_q.size() != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    reg_writes++;
    case (idx)
      REG_SEQUENCE_MODE: if (m_stage == STAGE_IDLE && val[2:0] < NUM_MODES) begin
        cfg_mode = val[2:0];
        m_phase  = '0;
        release_motor(4'h0);
      end
      REG_REVERSE_WIRING: cfg_reverse    = val[0];
      REG_PRECHARGE:      cfg_precharge  = val[15:0];
      REG_FINAL_HOLD:     cfg_hold       = val[15:0];
      REG_START_INTERVAL: cfg_start_iv   = val[15:0];
      REG_MIN_INTERVAL:   cfg_min_iv     = val[15:0];
      REG_RAMP_EVERY:     cfg_ramp_every = val[7:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] pick_steps();
    int unsigned r;
    logic signed [31:0] s;
    r = $urandom_range(0, 19);
    if (r < 14) s = $urandom_range(1, 6);
    else if (r == 14) s = $urandom;
    else if (r == 15) s = 0;
    else if (r == 16) s = 32'sh8000_0000;
    else if (r == 17) s = 32'sh7FFF_FFFF;
    else s = $urandom_range(7, 30);
    if ($urandom_range(0, 1) == 1) s = -s;
    return s;
  endfunction

  function automatic logic [15:0] pick_interval();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 17) return 16'($urandom_range(0, 6));
    else if (r < 19) return 16'($urandom);
    else return 16'hFFFF;
  endfunction

  task automatic test_idle_words();
    send_word(KIND_TICK, 0, 0, 0);
    send_word(KIND_STOP, 0, 0, 0);
    send_word(KIND_PATTERN, 0, 0, 4'hF);
    send_word(KIND_PATTERN, 0, 0, 4'h0);
    send_word(KIND_MOVE, 0, 3, 0);
    send_word(KIND_MOVE, 32'sh8000_0000, 3, 0);
  endtask

  task automatic test_zero_gaps();
    drain_results();
    write_reg(REG_PRECHARGE, 0);
    write_reg(REG_FINAL_HOLD, 0);
    write_reg(REG_START_INTERVAL, 2);
    write_reg(REG_MIN_INTERVAL, 0);
    write_reg(REG_RAMP_EVERY, 0);
    write_reg(REG_SEQUENCE_MODE, MODE_WAVE_ACBD);
    write_reg(REG_REVERSE_WIRING, 1);
    send_word(KIND_MOVE, 3, 0, 0);
    repeat (5) send_word(KIND_TICK, 0, 0, 0);
  endtask

  task automatic test_move_extremes();
    drain_results();
    write_reg(REG_PRECHARGE, 16'hFFFF);
    write_reg(REG_FINAL_HOLD, 16'hFFFF);
    write_reg(REG_START_INTERVAL, 16'hFFFF);
    write_reg(REG_MIN_INTERVAL, 1);
    write_reg(REG_RAMP_EVERY, 8'hFF);
    write_reg(REG_SEQUENCE_MODE, MODE_DUAL_ABDC);
    write_reg(REG_REVERSE_WIRING, 0);
    send_word(KIND_MOVE, 32'sh7FFF_FFFF, 16'hFFFF, 0);
    send_word(KIND_MOVE, -1, 0, 0);
    send_word(KIND_TICK, 0, 0, 0);
    send_word(KIND_TICK, 0, 0, 0);
    send_word(KIND_PATTERN, 0, 0, 4'h5);
    send_word(KIND_MOVE, -1, 0, 0);
    send_word(KIND_TICK, 0, 0, 0);
    send_word(KIND_STOP, 0, 0, 0);
  endtask

  task automatic test_mode_writes();
    send_word(KIND_MOVE, 5, 1, 0);
    drain_results();
    // mode change is dropped while a move is running
    write_reg(REG_SEQUENCE_MODE, MODE_WAVE_ABCD);
    send_word(KIND_TICK, 0, 0, 0);
    send_word(KIND_STOP, 0, 0, 0);
    drain_results();
    write_reg(REG_SEQUENCE_MODE, NUM_MODES);
    write_reg(REG_SEQUENCE_MODE, MODE_UNUSED);
    write_reg(BAD_REG_IDX, 32'h1);
    write_reg(REG_SEQUENCE_MODE, {29'd1, MODE_WAVE_ACBD});
    write_reg(REG_PRECHARGE, 0);
    write_reg(REG_FINAL_HOLD, 0);
    send_word(KIND_MOVE, 1, 0, 0);
    send_word(KIND_TICK, 0, 0, 0);
    send_word(KIND_TICK, 0, 0, 0);
  endtask

  task automatic test_output_backpressure();
    drain_results();
    write_reg(REG_PRECHARGE, 2);
    write_reg(REG_FINAL_HOLD, 2);
    write_reg(REG_START_INTERVAL, 3);
    write_reg(REG_MIN_INTERVAL, 1);
    write_reg(REG_RAMP_EVERY, 1);
    steady_send = 1'b1;
    holdoff_req = 1'b1;
    send_word(KIND_MOVE, 4, 1, 0);
    repeat (40) send_word(KIND_TICK, 0, 0, 0);
    steady_send = 1'b0;
    drain_results();
  endtask

  task automatic test_random_moves();
    int unsigned goal, ticks, r;
    bit wide;
    goal = useful_words + 760;
    while (useful_words < goal) begin
      drain_results();
      wide = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 1) == 1)
        write_reg(REG_SEQUENCE_MODE, {29'($urandom), 3'($urandom_range(0, 7))});
      write_reg(REG_REVERSE_WIRING, $urandom);
      if (wide) begin
        write_reg(REG_PRECHARGE,
                  {16'($urandom_range(0, 65535)), {16{$urandom_range(0, 1) == 1}}});
        write_reg(REG_FINAL_HOLD,
                  {16'($urandom_range(0, 65535)), {16{$urandom_range(0, 1) == 1}}});
        write_reg(REG_START_INTERVAL,
                  {16'($urandom_range(0, 65535)), {16{$urandom_range(0, 1) == 1}}});
        write_reg(REG_MIN_INTERVAL,
                  {16'($urandom_range(0, 65535)), {16{$urandom_range(0, 1) == 1}}});
        write_reg(REG_RAMP_EVERY, {24'($urandom), {8{$urandom_range(0, 1) == 1}}});
      end else begin
        write_reg(REG_PRECHARGE,
                  {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 3))});
        write_reg(REG_FINAL_HOLD,
                  {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 3))});
        write_reg(REG_START_INTERVAL,
                  {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 6))});
        write_reg(REG_MIN_INTERVAL,
                  {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 3))});
        write_reg(REG_RAMP_EVERY, {24'($urandom), 8'($urandom_range(0, 3))});
      end
      settings_phases++;
      steady_send = ($urandom_range(0, 3) == 0);
      steady_take = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 6)) begin
        r = $urandom_range(0, 7);
        if (r == 0) send_word(KIND_TICK, $urandom, 16'($urandom), 4'($urandom));
        else if (r == 1) send_word(KIND_PATTERN, $urandom, 16'($urandom), 4'($urandom));
        else if (r == 2) send_word(KIND_STOP, $urandom, 16'($urandom), 4'($urandom));
        send_word(KIND_MOVE, pick_steps(), pick_interval(), 4'($urandom));
        ticks = 0;
        while (m_stage != STAGE_IDLE && ticks < MOVE_TICK_CAP) begin
          r = $urandom_range(0, 39);
          if (r == 0) send_word(KIND_STOP, $urandom, 16'($urandom), 4'($urandom));
          else if (r == 1) send_word(KIND_PATTERN, $urandom, 16'($urandom), 4'($urandom));
          else if (r == 2) send_word(KIND_MOVE, pick_steps(), pick_interval(), 4'($urandom));
          else send_word(KIND_TICK, $urandom, 16'($urandom), 4'($urandom));
          ticks++;
        end
        if (m_stage != STAGE_IDLE)
          send_word(KIND_STOP, $urandom, 16'($urandom), 4'($urandom));
      end
    end
    steady_send = 1'b0;
    steady_take = 1'b0;
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin : take_results
    int unsigned stall_left;
    res_t want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid_o && out_ready) begin
        if (expected_drive_q.size() == 0) begin
          report_mismatch("word with nothing expected", coils_o, 0);
        end else begin
          want = expected_drive_q.pop_front();
          words_checked++;
          if (coils_o !== want.coils) report_mismatch("coils", coils_o, want.coils);
          if (busy_res_o !== want.busy) report_mismatch("busy", busy_res_o, want.busy);
          if (stage_o !== want.stage) report_mismatch("stage", stage_o, want.stage);
          if (accepted_o !== want.accepted)
            report_mismatch("accepted", accepted_o, want.accepted);
          if (steps_left_o !== want.steps_left)
            report_mismatch("steps_left", steps_left_o, want.steps_left);
        end
        stall_left = steady_take ? 0 : $urandom_range(0, 9);
      end
      if (holdoff_req) begin
        stall_left  = HOLDOFF_CYCLES;
        holdoff_req = 1'b0;
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cfg_mode       = RST_MODE;
    cfg_reverse    = 1'b0;
    cfg_precharge  = RST_PRECHARGE;
    cfg_hold       = RST_FINAL_HOLD;
    cfg_start_iv   = RST_START_IV;
    cfg_min_iv     = RST_MIN_IV;
    cfg_ramp_every = RST_RAMP_EVERY;
    m_phase        = '0;
    m_down         = 1'b0;
    m_left         = '0;
    m_target       = RST_MIN_IV;
    m_gap          = RST_START_IV;
    m_ticks        = '0;
    m_ramp         = '0;
    m_stage        = STAGE_IDLE;
    m_coils        = 4'h0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_words();
    test_zero_gaps();
    test_move_extremes();
    test_mode_writes();
    test_output_backpressure();
    test_random_moves();
    drain_results();
    repeat (8) @(posedge clk);
    $display("checked %0d result words, %0d moves taken, %0d register writes",
             words_checked, moves_taken, reg_writes);
    $display("ticks, moves, stops and raw patterns over %0d random settings plus directed edges",
             settings_phases);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
